>>> hw/rtl/tpwd_pkg.sv
package tpwd_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RunW    = 3;
  localparam int unsigned CountW  = 3;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] HighThresholdRst = 8'd128;
  localparam logic [CfgW-1:0] LeadLevelRst     = 8'd127;

  localparam logic [RunW-1:0]   RunMax    = 3'd7;
  localparam logic [CountW-1:0] LastBit   = 3'd7;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgHighThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLeadLevel     = 2'd1;

  // handshake between the decoder and its neighbors
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

>>> hw/rtl/tape_pulse_width_bit_decoder_unit.sv
// channel     | dir | beat content (tdata, low bit first)
// s_axis      | in  | sample [7:0]
// m_axis      | out | data_byte [7:0], first received bit in bit 7
// cfg         | in  | idx 0 high_threshold, idx 1 lead_level, others dropped
// One sample per cycle unless m_axis stalls a waiting byte; a sample is held
// in the input register and its byte, if any, then in the output register.
// Reset returns to lead-in skipping with thresholds 128 / 127.
// A stalled m_axis holds the decoder; an empty input register still takes one
// more beat, then s_axis_tready drops until the byte leaves.
module tape_pulse_width_bit_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tpwd_pkg::SampleW-1:0]  s_axis_tdata,  // [7:0] sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tpwd_pkg::ByteW-1:0]    m_axis_tdata,  // [7:0] data_byte
  input  logic                          cfg_we_i,
  input  logic [tpwd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpwd_pkg::CfgW-1:0]     cfg_wdata_i
);

  tpwd_pkg::hs_t                    smp_hs;
  logic [tpwd_pkg::SampleW-1:0]     smp_data;
  logic                             byte_valid;
  logic [tpwd_pkg::ByteW-1:0]       byte_data;

  tpwd_pipe_reg #(
    .Width (tpwd_pkg::SampleW)
  ) u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (smp_hs.valid),
    .out_ready_i (smp_hs.ready),
    .out_data_o  (smp_data)
  );

  tpwd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .smp_hs_i     (smp_hs),
    .sample_i     (smp_data),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_data)
  );

  tpwd_pipe_reg #(
    .Width (tpwd_pkg::ByteW)
  ) u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_valid),
    .in_ready_o  (smp_hs.ready),
    .in_data_i   (byte_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> hw/rtl/tpwd_pipe_reg.sv
module tpwd_pipe_reg #(
  parameter int unsigned Width = tpwd_pkg::SampleW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // a beat can enter while the held one leaves in the same cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

>>> hw/rtl/tpwd_core.sv
module tpwd_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpwd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tpwd_pkg::CfgW-1:0]         cfg_wdata_i,
  input  tpwd_pkg::hs_t                     smp_hs_i,
  input  logic [tpwd_pkg::SampleW-1:0]      sample_i,
  output logic                              byte_valid_o,
  output logic [tpwd_pkg::ByteW-1:0]        byte_o
);

  typedef enum logic [1:0] {
    PhLead   = 2'd0,
    PhSync   = 2'd1,
    PhDecode = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic                            prev_hi_q, prev_hi_d;
  logic [tpwd_pkg::RunW-1:0]       run_q, run_d, run_new;
  logic [tpwd_pkg::CountW-1:0]     cnt_q, cnt_d;
  logic [tpwd_pkg::ByteW-1:0]      shift_q, shift_d, shift_new;
  logic [tpwd_pkg::CfgW-1:0]       thr_q, lead_q;

  logic fire, hi, falling, run_short, run_long, got_bit;

  assign fire    = smp_hs_i.valid && smp_hs_i.ready;
  assign hi      = sample_i > thr_q;
  assign falling = !hi && prev_hi_q;

  always_comb begin
    run_new = (hi && !prev_hi_q) ? '0 : run_q;
    if (hi && run_new < tpwd_pkg::RunMax) begin
      run_new = run_new + 1'b1;
    end
  end

  assign run_short = (run_new == 3'd1) || (run_new == 3'd2);
  assign run_long  = (run_new == 3'd3) || (run_new == 3'd4);
  assign got_bit   = falling && (run_short || run_long);

  always_comb begin
    shift_new = shift_q;
    if (run_long) begin
      shift_new[tpwd_pkg::LastBit - cnt_q] = 1'b1;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    prev_hi_d    = hi;
    run_d        = run_new;
    cnt_d        = cnt_q;
    shift_d      = shift_q;
    byte_valid_o = 1'b0;
    byte_o       = shift_new;
    case (phase_q)
      PhLead: begin
        if (sample_i > lead_q) begin
          prev_hi_d = prev_hi_q;
          run_d     = run_q;
        end else if (falling && run_short) begin
          // the sample that closes lead-in already ends a sync pulse
          phase_d   = PhDecode;
          prev_hi_d = 1'b0;
          run_d     = '0;
        end else begin
          phase_d = PhSync;
        end
      end
      PhSync: begin
        if (falling && run_short) begin
          phase_d   = PhDecode;
          prev_hi_d = 1'b0;
          run_d     = '0;
        end
      end
      default: begin
        if (got_bit) begin
          if (cnt_q == tpwd_pkg::LastBit) begin
            byte_valid_o = fire;
            shift_d      = '0;
            cnt_d        = '0;
          end else begin
            shift_d = shift_new;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLead;
      prev_hi_q <= 1'b0;
      run_q     <= '0;
      cnt_q     <= '0;
      shift_q   <= '0;
      thr_q     <= tpwd_pkg::HighThresholdRst;
      lead_q    <= tpwd_pkg::LeadLevelRst;
    end else begin
      if (fire) begin
        phase_q   <= phase_d;
        prev_hi_q <= prev_hi_d;
        run_q     <= run_d;
        cnt_q     <= cnt_d;
        shift_q   <= shift_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tpwd_pkg::CfgHighThreshold: thr_q  <= cfg_wdata_i;
          tpwd_pkg::CfgLeadLevel:     lead_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule
